// File: rtl/cfss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cfss_pkg;

  // Needle store depth and derived widths
  localparam int MAX_NEEDLE = 64;
  localparam int IDX_W      = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
  localparam int LEN_W      = $clog2(MAX_NEEDLE + 1);

  // Fixed field widths
  localparam int OP_W     = 2;
  localparam int POS_W    = 6;
  localparam int BYTE_W   = 8;
  localparam int CFG_LEN_W = 7;

  // Case folding: lower-case ASCII letters map onto upper case
  localparam logic [BYTE_W-1:0] FOLD_BASE = 8'h60;
  localparam logic [BYTE_W-1:0] FOLD_STEP = 8'd32;
  localparam logic [BYTE_W-1:0] ALPHA_CNT = 8'd26;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_FEED = 2'd1,
    OP_END  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // Strobes from the item stage into the match unit
  typedef struct packed {
    logic feed;
    logic finish;
  } cfss_ctrl_t;

  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] k;
    k = c - FOLD_BASE;
    if ((k >= 8'd1) && (k <= ALPHA_CNT)) begin
      return c - FOLD_STEP;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/cfss_needle_row.sv
`timescale 1ns / 1ps
`default_nettype none

module cfss_needle_row
  import cfss_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [IDX_W-1:0]      wr_idx,
  input  wire logic [BYTE_W-1:0]     wr_byte,
  input  wire logic [BYTE_W-1:0]     cmp_byte,
  output logic      [MAX_NEEDLE-1:0] hit
);

  // One folded needle byte per lane; each lane compares at its own place
  logic [BYTE_W-1:0] needle_r [MAX_NEEDLE];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      needle_r[wr_idx] <= fold_byte(wr_byte);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      hit[i] = (needle_r[i] == cmp_byte);
    end
  end

endmodule

`default_nettype wire

// File: rtl/cfss_match.sv
`timescale 1ns / 1ps
`default_nettype none

module cfss_match
  import cfss_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cfss_ctrl_t            ctrl,
  input  wire logic [MAX_NEEDLE-1:0] hit,
  input  wire logic [LEN_W-1:0]      len_u,
  output logic                       found
);

  logic [MAX_NEEDLE-1:0] pm_r;
  logic [MAX_NEEDLE-1:0] pm_nxt;
  logic                  seen_r;
  logic                  seen_nxt;
  logic [MAX_NEEDLE-1:0] feed_vec;
  logic [MAX_NEEDLE-1:0] last_mask;

  // Shift-and step: lane i extends the run that ended in lane i-1
  always_comb begin
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      last_mask[i] = (len_u == LEN_W'(i + 1));
      if (i == 0) begin
        feed_vec[i] = (LEN_W'(i) < len_u) && hit[i];
      end else begin
        feed_vec[i] = (LEN_W'(i) < len_u) && pm_r[i-1] && hit[i];
      end
    end
  end

  always_comb begin
    pm_nxt   = pm_r;
    seen_nxt = seen_r;
    if (ctrl.finish) begin
      pm_nxt   = '0;
      seen_nxt = 1'b0;
    end else if (ctrl.feed) begin
      pm_nxt   = feed_vec;
      seen_nxt = seen_r | (|(feed_vec & last_mask));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_r   <= '0;
      seen_r <= 1'b0;
    end else begin
      pm_r   <= pm_nxt;
      seen_r <= seen_nxt;
    end
  end

  assign found = (len_u == '0) || seen_r;

  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.finish |=> (pm_r == '0) && !seen_r)
    else $error("match state not cleared after end of haystack");

  a_seen_from_feed: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(seen_r) |-> $past(ctrl.feed))
    else $error("match flag set without a haystack byte");

  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.feed && ctrl.finish))
    else $error("feed and finish strobes together");

endmodule

`default_nettype wire

// File: rtl/case_fold_substring_search_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | handshake              | beat contents
// ---------+------------------------+---------------------------------------
// in_      | in_valid / in_ready    | in_opcode, in_position, in_data_byte
// out_     | out_valid / out_ready  | out_found (one beat per end of haystack)
// config   | APB psel/penable/...   | reg 0 at byte 0: needle_length [6:0]
//
// Each item sits in the item register and retires unless it is an end beat
// held by a full result slot; otherwise one haystack byte is taken per clock.
// Lane compares against all needle bytes run in parallel, so rate is set by
// the single item register stage and the output register, not by length.
// Only end-of-haystack beats wait on out_ready; other opcodes never stall.
// rst_n is synchronous: it clears valid flags, length and match state; the
// needle store is not cleared and must be loaded before use.

module case_fold_substring_search_unit
  import cfss_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [OP_W-1:0]      in_opcode,
  input  wire logic [POS_W-1:0]     in_position,
  input  wire logic [BYTE_W-1:0]    in_data_byte,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_found,
  // configuration port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready
);

  localparam int CMP_W = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;
  localparam int PCMP_W = (IDX_W + 1 > POS_W + 1) ? IDX_W + 1 : POS_W + 1;

  // Item register
  logic              item_vld_r;
  op_t               item_op_r;
  logic [POS_W-1:0]  item_pos_r;
  logic [BYTE_W-1:0] item_byte_r;

  // Result register
  logic              out_vld_r;
  logic              out_vld_nxt;
  logic              out_found_r;

  logic [CFG_LEN_W-1:0] needle_length_r;

  logic              item_adv;
  logic              in_take;
  logic              cfg_wr;
  logic              reg_sel;
  cfss_ctrl_t        ctrl;
  logic [LEN_W-1:0]  len_u;
  logic [CMP_W-1:0]  len_cmp;
  logic [PCMP_W-1:0] pos_cmp;
  logic              wr_en;
  logic [MAX_NEEDLE-1:0] hit;
  logic              found;

  // Retire the held item unless it is an end beat and the result slot is full
  assign item_adv = item_vld_r &&
                    ((item_op_r != OP_END) || !out_vld_r || out_ready);
  assign in_ready = !item_vld_r || item_adv;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  // Payload: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_op_r   <= op_t'(in_opcode);
      item_pos_r  <= in_position;
      item_byte_r <= in_data_byte;
    end
  end

  // Length register; values above the store depth act as full depth
  assign reg_sel = (paddr[2] == 1'b0);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(32 - CFG_LEN_W){1'b0}}, needle_length_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_length_r <= '0;
    end else if (cfg_wr) begin
      needle_length_r <= pwdata[CFG_LEN_W-1:0];
    end
  end

  assign len_cmp = CMP_W'(needle_length_r);
  assign len_u   = (len_cmp > CMP_W'(MAX_NEEDLE)) ? LEN_W'(MAX_NEEDLE)
                                                  : LEN_W'(len_cmp);

  // Drop needle writes that fall outside the store
  assign pos_cmp = PCMP_W'(item_pos_r);
  assign wr_en   = item_adv && (item_op_r == OP_LOAD) &&
                   (pos_cmp < PCMP_W'(MAX_NEEDLE));

  assign ctrl.feed   = item_adv && (item_op_r == OP_FEED);
  assign ctrl.finish = item_adv && (item_op_r == OP_END);

  cfss_needle_row u_row (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_idx   (pos_cmp[IDX_W-1:0]),
    .wr_byte  (item_byte_r),
    .cmp_byte (fold_byte(item_byte_r)),
    .hit      (hit)
  );

  cfss_match u_match (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .hit   (hit),
    .len_u (len_u),
    .found (found)
  );

  // Result slot: advance on take, reload on a retiring end beat
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_vld_r && out_ready) begin
      out_vld_nxt = 1'b0;
    end
    if (ctrl.finish) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      out_found_r <= found;
    end
  end

  assign out_valid = out_vld_r;
  assign out_found = out_found_r;

  a_no_stall_other: assert property (@(posedge clk) disable iff (!rst_n)
    (item_vld_r && (item_op_r != OP_END)) |-> in_ready)
    else $error("non-end beat stalled the input");

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.finish |=> out_valid)
    else $error("end beat retired without a result");

  a_end_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (item_vld_r && (item_op_r == OP_END) && out_vld_r && !out_ready) |-> !in_ready)
    else $error("input accepted while end beat is blocked");

endmodule

`default_nettype wire
